/* hw/rtl/bmm_pkg.sv */
// ----------------------------------------------------------------------------
// bmm_pkg
// Shared constants for the Barrett modular multiplier: pipeline depth,
// working word width and register map of the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

package bmm_pkg;

   // register stages between the request and the response side
   localparam int NUM_STAGES = 7;

   // wrap-around width of the remainder arithmetic
   localparam int WIDE_BITS = 64;

   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MODULUS = 2'd0,
      CSR_FACTOR  = 2'd1
   } csr_index_type;

   localparam logic [WIDE_BITS-1:0] MODULUS_RESET = 64'd754974721;
   localparam logic [WIDE_BITS-1:0] FACTOR_RESET  = 64'd1527099480;

endpackage

`default_nettype wire

/* hw/rtl/bmm_flow.sv */
// ----------------------------------------------------------------------------
// bmm_flow
// Valid and ready chain for a linear pipeline: each stage loads when it is
// empty or when the stage after it moves on, so bubbles are squeezed out.
// ----------------------------------------------------------------------------
`default_nettype none

module bmm_flow #(
   parameter int STAGES = 7
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [STAGES-1:0]      load
);

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] rdy;

   always_comb begin
      rdy[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
      valid_in[0] = rdy[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = rdy[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[STAGES-1];
   assign load      = rdy;

`ifndef SYNTHESIS
   a_reset_empties : assert property (@(posedge clock)
      reset |=> (valid_ff == '0))
      else $error("pipeline not empty after reset");

   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> valid_ff[0])
      else $error("input refused while first stage empty");

   a_full_stall_blocks : assert property (@(posedge clock) disable iff (reset)
      ((&valid_ff) && !out_ready) |-> !in_ready)
      else $error("full stalled pipeline still takes input");

   a_hold_when_stalled : assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> out_valid)
      else $error("result dropped while stalled");
`endif

endmodule

`default_nettype wire

/* hw/rtl/barrett_modular_multiplier.sv */
// ----------------------------------------------------------------------------
// barrett_modular_multiplier
// Pipelined modular multiplier: x * y mod p by Barrett reduction.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : operand word, tdata = {operand_y, operand_x}, operand_x lowest.
//   rsp_*  : result word, tdata = product_mod in the low bits, zero padded.
//   csr_*  : register writes; index 0 = modulus, index 1 = barrett_factor
//            (floor(2^(2*MOD_BITS) / modulus)); other indexes are dropped.
//            Write only while the pipeline is empty; csr_ready is always high.
// One operand pair is taken every cycle unless the pipeline stalls. One
// stage each: full product, estimate partials, their sum and shift,
// quotient times modulus partials, summing subtract, then the two
// conditional corrections.
// Reset (synchronous, active high) empties the pipeline and loads the
// default modulus 754974721 with its matching factor.
// When the receiver stalls, stages fill up behind the held response; input
// is refused only once every stage holds a word, and nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module barrett_modular_multiplier import bmm_pkg::*; #(
   parameter int MOD_BITS = 30
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // req_tdata: operand_x, operand_y (lowest first), zero padded
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [((2*MOD_BITS+7)/8)*8-1:0]   req_tdata,
   // rsp_tdata: product_mod, zero padded
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [((MOD_BITS+7)/8)*8-1:0]          rsp_tdata,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0]         csr_index,
   input  wire logic [2*MOD_BITS-1:0]             csr_data
);

   localparam int M       = MOD_BITS;
   localparam int OUT_TDW = ((M + 7) / 8) * 8;
   localparam int EXTW    = (3 * M > WIDE_BITS) ? 3 * M : WIDE_BITS;

   // configuration registers
   logic [M-1:0]   modulus_ff;
   logic [2*M-1:0] factor_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET[M-1:0];
         factor_ff  <= FACTOR_RESET[2*M-1:0];
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MODULUS: begin
               modulus_ff <= csr_data[M-1:0];
            end
            CSR_FACTOR: begin
               factor_ff <= csr_data;
            end
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   // pipeline flow control
   logic [NUM_STAGES-1:0] load;

   bmm_flow #(
      .STAGES (NUM_STAGES)
   ) u_flow (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .load      (load)
   );

   // stage 1: full product
   logic [M-1:0]   opnd_x;
   logic [M-1:0]   opnd_y;
   logic [2*M-1:0] s1_prod_ff;
   logic [2*M-1:0] s1_prod_in;

   assign opnd_x     = req_tdata[M-1:0];
   assign opnd_y     = req_tdata[2*M-1:M];
   assign s1_prod_in = (2*M)'(opnd_x) * (2*M)'(opnd_y);

   // stage 2: top bits of the product times each half of the factor
   logic [M:0]     est_a;
   logic [2*M:0]   s2_pl_ff, s2_pl_in;
   logic [2*M:0]   s2_ph_ff, s2_ph_in;
   logic [2*M-1:0] s2_prod_ff;

   assign est_a    = s1_prod_ff[2*M-1:M-1];
   assign s2_pl_in = (2*M+1)'(est_a) * (2*M+1)'(factor_ff[M-1:0]);
   assign s2_ph_in = (2*M+1)'(est_a) * (2*M+1)'(factor_ff[2*M-1:M]);

   // stage 3: sum the partials and shift down to the quotient estimate
   logic [3*M:0]   est_full;
   logic [2*M-1:0] s3_q_ff, s3_q_in;
   logic [2*M-1:0] s3_prod_ff;

   assign est_full = ((3*M+1)'(s2_ph_ff) << M) + (3*M+1)'(s2_pl_ff);
   assign s3_q_in  = est_full[3*M:M+1];

   // stage 4: quotient halves times the modulus
   logic [2*M-1:0] s4_ql_ff, s4_ql_in;
   logic [2*M-1:0] s4_qh_ff, s4_qh_in;
   logic [2*M-1:0] s4_prod_ff;

   assign s4_ql_in = (2*M)'(s3_q_ff[M-1:0]) * (2*M)'(modulus_ff);
   assign s4_qh_in = (2*M)'(s3_q_ff[2*M-1:M]) * (2*M)'(modulus_ff);

   // stage 5: raw remainder, wrapping at the working width
   logic [EXTW-1:0]      qp_ext;
   logic [WIDE_BITS-1:0] s5_r_ff, s5_r_in;

   assign qp_ext  = (EXTW'(s4_qh_ff) << M) + EXTW'(s4_ql_ff);
   assign s5_r_in = WIDE_BITS'(s4_prod_ff) - qp_ext[WIDE_BITS-1:0];

   // stages 6 and 7: conditional corrections
   logic [WIDE_BITS-1:0] mod_wide;
   logic [WIDE_BITS-1:0] s6_r_ff, s6_r_in;
   logic [WIDE_BITS-1:0] fix2;
   logic [M-1:0]         s7_res_ff, s7_res_in;

   assign mod_wide  = WIDE_BITS'(modulus_ff);
   assign s6_r_in   = (s5_r_ff >= mod_wide) ? s5_r_ff - mod_wide : s5_r_ff;
   assign fix2      = (s6_r_ff >= mod_wide) ? s6_r_ff - mod_wide : s6_r_ff;
   assign s7_res_in = fix2[M-1:0];

   // payload registers advance with their stage's load enable
   always_ff @(posedge clock) begin
      if (load[0]) begin
         s1_prod_ff <= s1_prod_in;
      end
      if (load[1]) begin
         s2_pl_ff   <= s2_pl_in;
         s2_ph_ff   <= s2_ph_in;
         s2_prod_ff <= s1_prod_ff;
      end
      if (load[2]) begin
         s3_q_ff    <= s3_q_in;
         s3_prod_ff <= s2_prod_ff;
      end
      if (load[3]) begin
         s4_ql_ff   <= s4_ql_in;
         s4_qh_ff   <= s4_qh_in;
         s4_prod_ff <= s3_prod_ff;
      end
      if (load[4]) begin
         s5_r_ff <= s5_r_in;
      end
      if (load[5]) begin
         s6_r_ff <= s6_r_in;
      end
      if (load[6]) begin
         s7_res_ff <= s7_res_in;
      end
   end

   assign rsp_tdata = OUT_TDW'(s7_res_ff);

endmodule

`default_nettype wire
